// File: rtl/rrc_pkg.sv
`timescale 1ns / 1ps

package rrc_pkg;

	// CORDIC depth, one pipeline stage per iteration (8..24)
	localparam int TRIG_STAGES = 16;
	localparam int ATAN_LEN    = 24;

	// 360 degrees in 1/128 degree units = 45 * 1024
	localparam int DEG_UNITS   = 46080;
	localparam int ANG_GRAIN   = 45;

	// floor(m / 45) == (m * 46604) >> 21 for every m below 2^16
	localparam logic [15:0] INV45_Q21   = 16'd46604;
	localparam int          INV45_SHIFT = 21;

	// CORDIC gain 0.60725... in Q.30
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// binary angle, 2^-32 turn per lsb
	localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
	localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

	typedef logic [31:0] atan_tbl_t [0:ATAN_LEN-1];

	// atan(2^-i) in 2^-32 turn units
	localparam atan_tbl_t ATAN_TURNS = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// low 22 bits of the binary angle for remainder r of m / 45:
	// round(r * 2^22 / 45), ties up
	typedef logic [21:0] frac_tbl_t [0:63];

	function automatic frac_tbl_t build_frac_tbl();
		frac_tbl_t t;
		for (int r = 0; r < 64; r++) begin
			if (r < ANG_GRAIN) begin
				t[r] = 22'(((64'(r) << 22) + 64'd22) / 64'd45);
			end else begin
				t[r] = '0;
			end
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

	typedef struct packed {
		logic signed [31:0] mid_x;
		logic signed [31:0] mid_y;
		logic [23:0]        length_x;
		logic [23:0]        length_y;
	} geom_t;

	typedef struct packed {
		logic signed [31:0] c1x;
		logic signed [31:0] c1y;
		logic signed [31:0] c2x;
		logic signed [31:0] c2y;
		logic signed [31:0] c3x;
		logic signed [31:0] c3y;
		logic signed [31:0] c4x;
		logic signed [31:0] c4y;
	} corners_t;

endpackage

// File: rtl/rrc_angle.sv
`timescale 1ns / 1ps

module rrc_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [16:0] angle,
	input  rrc_pkg::geom_t     geom_in,
	output logic               out_valid,
	output logic signed [32:0] z_out,
	output logic               flip_out,
	output rrc_pkg::geom_t     geom_out
);
	import rrc_pkg::*;

	// s1: reduce to 0..46079
	logic signed [18:0] a_ext;
	logic signed [18:0] m_wide;
	logic               vld_s1;
	logic [15:0]        m_s1;
	geom_t              geom_s1;

	// s2: reciprocal multiply
	logic               vld_s2;
	logic [31:0]        prod_s2;
	logic [15:0]        m_s2;
	geom_t              geom_s2;

	// s3: quotient and remainder by 45
	logic [9:0]         q;
	logic [15:0]        qx45;
	logic [15:0]        r_full;
	logic               vld_s3;
	logic [9:0]         q_s3;
	logic [5:0]         r_s3;
	geom_t              geom_s3;

	// s4: binary angle, fold into +-quarter turn
	logic signed [32:0] z_raw;
	logic signed [32:0] z_fold;
	logic               flip;
	logic               vld_s4;
	logic signed [32:0] z_s4;
	logic               flip_s4;
	geom_t              geom_s4;

	always_comb begin
		a_ext = {{2{angle[16]}}, angle};
		if (a_ext < -19'sd46080) begin
			m_wide = a_ext + 19'sd92160;
		end else if (a_ext < 19'sd0) begin
			m_wide = a_ext + 19'sd46080;
		end else if (a_ext >= 19'sd46080) begin
			m_wide = a_ext - 19'sd46080;
		end else begin
			m_wide = a_ext;
		end
	end

	always_comb begin
		q      = prod_s2[INV45_SHIFT +: 10];
		qx45   = {6'b0, q} * 16'(ANG_GRAIN);
		r_full = m_s2 - qx45;
	end

	always_comb begin
		z_raw = $signed({q_s3[9], q_s3, FRAC_TBL[r_s3]});
		flip  = 1'b0;
		if (z_raw > QUARTER_TURN) begin
			z_fold = z_raw - HALF_TURN;
			flip   = 1'b1;
		end else if (z_raw < -QUARTER_TURN) begin
			z_fold = z_raw + HALF_TURN;
			flip   = 1'b1;
		end else begin
			z_fold = z_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= m_wide[15:0];
			geom_s1 <= geom_in;
			prod_s2 <= 32'(m_s1) * 32'(INV45_Q21);
			m_s2    <= m_s1;
			geom_s2 <= geom_s1;
			q_s3    <= q;
			r_s3    <= r_full[5:0];
			geom_s3 <= geom_s2;
			z_s4    <= z_fold;
			flip_s4 <= flip;
			geom_s4 <= geom_s3;
		end
	end

	assign out_valid = vld_s4;
	assign z_out     = z_s4;
	assign flip_out  = flip_s4;
	assign geom_out  = geom_s4;

	a_m_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (m_s1 < 16'(DEG_UNITS)))
		else $error("reduced angle out of range");

	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (r_s3 < 6'(ANG_GRAIN)))
		else $error("remainder by 45 out of range");

	a_z_fold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (z_s4 <= QUARTER_TURN && z_s4 >= -QUARTER_TURN))
		else $error("folded angle beyond a quarter turn");

endmodule

// File: rtl/rrc_cordic.sv
`timescale 1ns / 1ps

module rrc_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [32:0] z_in,
	input  logic               flip_in,
	input  rrc_pkg::geom_t     geom_in,
	output logic               out_valid,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic               flip_out,
	output rrc_pkg::geom_t     geom_out
);
	import rrc_pkg::*;

	logic               vld_s  [TRIG_STAGES];
	logic signed [31:0] cx_s   [TRIG_STAGES];
	logic signed [31:0] cy_s   [TRIG_STAGES];
	logic signed [32:0] cz_s   [TRIG_STAGES-1];
	logic               flip_s [TRIG_STAGES];
	geom_t              geom_s [TRIG_STAGES];

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
		logic               vi;
		logic signed [31:0] xi;
		logic signed [31:0] yi;
		logic signed [32:0] zi;
		logic               fi;
		geom_t              gi;
		logic signed [31:0] dx;
		logic signed [31:0] dy;

		if (i == 0) begin : g_first
			assign vi = in_valid;
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = z_in;
			assign fi = flip_in;
			assign gi = geom_in;
		end else begin : g_next
			assign vi = vld_s[i-1];
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign fi = flip_s[i-1];
			assign gi = geom_s[i-1];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					cx_s[i] <= xi - dx;
					cy_s[i] <= yi + dy;
				end else begin
					cx_s[i] <= xi + dx;
					cy_s[i] <= yi - dy;
				end
				flip_s[i] <= fi;
				geom_s[i] <= gi;
			end
		end

		// last iteration needs no residual angle
		if (i < TRIG_STAGES - 1) begin : g_z
			logic signed [32:0] at;

			assign at = $signed({1'b0, ATAN_TURNS[i]});

			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						cz_s[i] <= zi - at;
					end else begin
						cz_s[i] <= zi + at;
					end
				end
			end
		end
	end

	assign out_valid = vld_s[TRIG_STAGES-1];
	assign x_out     = cx_s[TRIG_STAGES-1];
	assign y_out     = cy_s[TRIG_STAGES-1];
	assign flip_out  = flip_s[TRIG_STAGES-1];
	assign geom_out  = geom_s[TRIG_STAGES-1];

endmodule

// File: rtl/rrc_corners.sv
`timescale 1ns / 1ps

module rrc_corners (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic               flip_in,
	input  rrc_pkg::geom_t     geom_in,
	output logic               out_valid,
	output rrc_pkg::corners_t  corners
);
	import rrc_pkg::*;

	localparam logic signed [57:0] RND = 58'sd1073741824;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -33'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// s1: undo the half-turn fold
	logic               vld_s1;
	logic signed [31:0] cos_s1;
	logic signed [31:0] sin_s1;
	geom_t              geom_s1;

	// s2: products
	logic signed [24:0] lx;
	logic signed [24:0] ly;
	logic signed [56:0] lxc;
	logic signed [56:0] lys;
	logic signed [56:0] lxs;
	logic signed [56:0] lyc;
	logic               vld_s2;
	logic signed [56:0] lxc_s2;
	logic signed [56:0] lys_s2;
	logic signed [56:0] lxs_s2;
	logic signed [56:0] lyc_s2;
	logic signed [31:0] mx_s2;
	logic signed [31:0] my_s2;

	// s3: half diagonals, rounded to the position grid
	logic signed [57:0] v1x;
	logic signed [57:0] v1y;
	logic signed [57:0] v2x;
	logic signed [57:0] v2y;
	logic               vld_s3;
	logic signed [26:0] h1x_s3;
	logic signed [26:0] h1y_s3;
	logic signed [26:0] h2x_s3;
	logic signed [26:0] h2y_s3;
	logic signed [31:0] mx_s3;
	logic signed [31:0] my_s3;

	// s4: corners, saturated
	logic               vld_s4;
	corners_t           corners_s4;
	corners_t           cn;

	assign lx  = $signed({1'b0, geom_s1.length_x});
	assign ly  = $signed({1'b0, geom_s1.length_y});
	assign lxc = lx * cos_s1;
	assign lys = ly * sin_s1;
	assign lxs = lx * sin_s1;
	assign lyc = ly * cos_s1;

	always_comb begin
		v1x = -58'(lxc_s2) - 58'(lys_s2) + RND;
		v1y = 58'(lyc_s2) - 58'(lxs_s2) + RND;
		v2x = 58'(lxc_s2) - 58'(lys_s2) + RND;
		v2y = 58'(lxs_s2) + 58'(lyc_s2) + RND;
	end

	always_comb begin
		cn.c1x = sat32(33'(mx_s3) + 33'(h1x_s3));
		cn.c1y = sat32(33'(my_s3) + 33'(h1y_s3));
		cn.c2x = sat32(33'(mx_s3) + 33'(h2x_s3));
		cn.c2y = sat32(33'(my_s3) + 33'(h2y_s3));
		cn.c3x = sat32(33'(mx_s3) - 33'(h1x_s3));
		cn.c3y = sat32(33'(my_s3) - 33'(h1y_s3));
		cn.c4x = sat32(33'(mx_s3) - 33'(h2x_s3));
		cn.c4y = sat32(33'(my_s3) - 33'(h2y_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1     <= flip_in ? -x_in : x_in;
			sin_s1     <= flip_in ? -y_in : y_in;
			geom_s1    <= geom_in;
			lxc_s2     <= lxc;
			lys_s2     <= lys;
			lxs_s2     <= lxs;
			lyc_s2     <= lyc;
			mx_s2      <= geom_s1.mid_x;
			my_s2      <= geom_s1.mid_y;
			h1x_s3     <= v1x[57:31];
			h1y_s3     <= v1y[57:31];
			h2x_s3     <= v2x[57:31];
			h2y_s3     <= v2y[57:31];
			mx_s3      <= mx_s2;
			my_s3      <= my_s2;
			corners_s4 <= cn;
		end
	end

	assign out_valid = vld_s4;
	assign corners   = corners_s4;

endmodule

// File: rtl/rrc_out.sv
`timescale 1ns / 1ps

module rrc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              p_valid,
	input  rrc_pkg::corners_t p_data,
	input  logic              stall,
	output logic              en,
	output logic              out_valid,
	output rrc_pkg::corners_t out_data
);
	import rrc_pkg::*;

	logic     out_vld_q;
	logic     skid_vld_q;
	corners_t out_q;
	corners_t skid_q;
	logic     out_ready;

	// pipeline moves whenever the skid slot is free
	assign en        = !skid_vld_q;
	assign out_ready = !out_vld_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= p_valid;
			end
		end else if (p_valid && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_q <= skid_vld_q ? skid_q : p_data;
		end else if (en) begin
			skid_q <= p_data;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds data while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && stall))
		else $error("skid filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !stall) |=> (out_vld_q && !skid_vld_q))
		else $error("skid not drained into output register");

endmodule

// File: rtl/rotated_rectangle_corners.sv
`timescale 1ns / 1ps
// Rotated rectangle corners.
// Input transaction: midpoint (mid_x, mid_y, signed Q23.8), side lengths
// (length_x, length_y, unsigned Q16.8) and angle (1/128 degree, anticlockwise,
// any value, wrapped modulo 360). Output transaction: the four corners, upper
// left first and then clockwise, each signed Q23.8 saturated to 32 bits.
// Both channels use valid/stall; a transaction moves on a clock edge with
// valid high and stall low.
// Throughput: one transaction per cycle while neither channel stalls. The path
// from input to output transaction is 4 stages of angle reduction (mod 360,
// reciprocal divide by 45, fold to +-90 degrees), one CORDIC stage per
// iteration (16), and 4 stages of sign fix, multiply, round and add/saturate,
// then the output register.
// The output register is backed by a one-entry skid buffer. item_stall is
// that buffer's full flag, so it is registered and does not depend on
// result_stall in the same cycle. While result_stall is held, at most one
// more transaction drains into the skid, then the whole pipeline freezes in
// place; nothing is dropped or repeated.
// Reset (arst_n low) clears all stage valid flags, including those of the output
// register and the skid; data registers are not reset.
module rotated_rectangle_corners (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] mid_x,
	input  logic signed [31:0] mid_y,
	input  logic [23:0]        length_x,
	input  logic [23:0]        length_y,
	input  logic signed [16:0] angle,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] corner1_x,
	output logic signed [31:0] corner1_y,
	output logic signed [31:0] corner2_x,
	output logic signed [31:0] corner2_y,
	output logic signed [31:0] corner3_x,
	output logic signed [31:0] corner3_y,
	output logic signed [31:0] corner4_x,
	output logic signed [31:0] corner4_y
);
	import rrc_pkg::*;

	logic               en;
	geom_t              geom_in;

	// angle front end
	logic               ang_valid;
	logic signed [32:0] ang_z;
	logic               ang_flip;
	geom_t              ang_geom;

	// CORDIC result, still folded
	logic               cor_valid;
	logic signed [31:0] cor_x;
	logic signed [31:0] cor_y;
	logic               cor_flip;
	geom_t              cor_geom;

	// corner stages
	logic               crn_valid;
	corners_t           crn_data;

	corners_t           res;

	assign geom_in.mid_x    = mid_x;
	assign geom_in.mid_y    = mid_y;
	assign geom_in.length_x = length_x;
	assign geom_in.length_y = length_y;

	// stalled exactly when the skid slot is occupied
	assign item_stall = !en;

	rrc_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.angle     (angle),
		.geom_in   (geom_in),
		.out_valid (ang_valid),
		.z_out     (ang_z),
		.flip_out  (ang_flip),
		.geom_out  (ang_geom)
	);

	rrc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ang_valid),
		.z_in      (ang_z),
		.flip_in   (ang_flip),
		.geom_in   (ang_geom),
		.out_valid (cor_valid),
		.x_out     (cor_x),
		.y_out     (cor_y),
		.flip_out  (cor_flip),
		.geom_out  (cor_geom)
	);

	rrc_corners u_corners (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cor_valid),
		.x_in      (cor_x),
		.y_in      (cor_y),
		.flip_in   (cor_flip),
		.geom_in   (cor_geom),
		.out_valid (crn_valid),
		.corners   (crn_data)
	);

	rrc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.p_valid   (crn_valid),
		.p_data    (crn_data),
		.stall     (result_stall),
		.en        (en),
		.out_valid (result_valid),
		.out_data  (res)
	);

	assign corner1_x = res.c1x;
	assign corner1_y = res.c1y;
	assign corner2_x = res.c2x;
	assign corner2_y = res.c2y;
	assign corner3_x = res.c3x;
	assign corner3_y = res.c3y;
	assign corner4_x = res.c4x;
	assign corner4_y = res.c4y;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import rrc_pkg::*;

	// Fixed-point helpers for the expected-corner math
	localparam longint HALF_TURN_L    = 64'sd2147483648;
	localparam longint QUARTER_TURN_L = 64'sd1073741824;
	localparam longint FULL_TURN_L    = 64'sd4294967296;
	localparam longint ROUND_Q31      = 64'sd1073741824;
	localparam longint MAX_Q32        = 64'sd2147483647;
	localparam longint MIN_Q32        = -64'sd2147483648;

	// Angles in 1/128 degree
	localparam logic signed [16:0] DEG_45  = 17'sd5760;
	localparam logic signed [16:0] DEG_90  = 17'sd11520;
	localparam logic signed [16:0] DEG_180 = 17'sd23040;
	localparam logic signed [16:0] DEG_270 = 17'sd34560;
	localparam logic signed [16:0] DEG_360 = 17'sd46080;

	localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

	// Pipeline is 25 deep plus skid; give a margin before calling it quiet
	localparam int DRAIN_CYCLES = 40;
	// Cycles with no transaction on either side before declaring a hang
	localparam int QUIET_LIMIT = 3000;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int MAX_PRINTED = 40;

	// Scoreboard: predicts the four corners of each accepted rectangle and
	// checks output transactions against them in order.
	class corner_scoreboard;
		corners_t expected_corners[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_corners.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTED) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endtask

		function longint clamp_q32(longint v);
			if (v > MAX_Q32) begin
				return MAX_Q32;
			end
			if (v < MIN_Q32) begin
				return MIN_Q32;
			end
			return v;
		endfunction

		// Angle reduction to a binary angle, fold into +-90 degrees, CORDIC
		// for cos/sin in Q.30, then rotated half-diagonals rounded to Q.8.
		function corners_t predict_corners(geom_t g, logic signed [16:0] ang);
			longint m, z, x, y, dx, dy, c, s, lx, ly, mx, my;
			longint r1x, r1y, r2x, r2y;
			bit flip;
			corners_t r;
			m = longint'(ang) % DEG_UNITS;
			if (m < 0) begin
				m += DEG_UNITS;
			end
			z = ((m << 32) + DEG_UNITS / 2) / DEG_UNITS;
			if (z >= HALF_TURN_L) begin
				z -= FULL_TURN_L;
			end
			flip = 1'b0;
			if (z > QUARTER_TURN_L) begin
				z -= HALF_TURN_L;
				flip = 1'b1;
			end else if (z < -QUARTER_TURN_L) begin
				z += HALF_TURN_L;
				flip = 1'b1;
			end
			x = longint'(GAIN_Q30);
			y = 0;
			for (int i = 0; i < TRIG_STAGES && i < ATAN_LEN; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ATAN_TURNS[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ATAN_TURNS[i]);
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			lx = longint'({40'd0, g.length_x});
			ly = longint'({40'd0, g.length_y});
			mx = longint'(g.mid_x);
			my = longint'(g.mid_y);
			r1x = (-lx * c - ly * s + ROUND_Q31) >>> 31;
			r1y = (-lx * s + ly * c + ROUND_Q31) >>> 31;
			r2x = (lx * c - ly * s + ROUND_Q31) >>> 31;
			r2y = (lx * s + ly * c + ROUND_Q31) >>> 31;
			r.c1x = 32'(clamp_q32(mx + r1x));
			r.c1y = 32'(clamp_q32(my + r1y));
			r.c2x = 32'(clamp_q32(mx + r2x));
			r.c2y = 32'(clamp_q32(my + r2y));
			r.c3x = 32'(clamp_q32(mx - r1x));
			r.c3y = 32'(clamp_q32(my - r1y));
			r.c4x = 32'(clamp_q32(mx - r2x));
			r.c4y = 32'(clamp_q32(my - r2y));
			return r;
		endfunction

		function void note_rect(geom_t g, logic signed [16:0] ang);
			expected_corners.push_back(predict_corners(g, ang));
		endfunction

		task check_corners(corners_t got);
			corners_t exp_c;
			logic signed [31:0] g_f [8];
			logic signed [31:0] e_f [8];
			string names [8];
			if (expected_corners.size() == 0) begin
				report_mismatch("output transaction with nothing expected");
				return;
			end
			exp_c = expected_corners.pop_front();
			names = '{"corner1_x", "corner1_y", "corner2_x", "corner2_y",
				"corner3_x", "corner3_y", "corner4_x", "corner4_y"};
			g_f = '{got.c1x, got.c1y, got.c2x, got.c2y,
				got.c3x, got.c3y, got.c4x, got.c4y};
			e_f = '{exp_c.c1x, exp_c.c1y, exp_c.c2x, exp_c.c2y,
				exp_c.c3x, exp_c.c3y, exp_c.c4x, exp_c.c4y};
			for (int k = 0; k < 8; k++) begin
				if (g_f[k] !== e_f[k]) begin
					report_mismatch($sformatf("%s got %0d expected %0d",
						names[k], g_f[k], e_f[k]));
				end
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic signed [31:0] mid_x;
	logic signed [31:0] mid_y;
	logic [23:0]        length_x;
	logic [23:0]        length_y;
	logic signed [16:0] angle;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [31:0] corner1_x;
	logic signed [31:0] corner1_y;
	logic signed [31:0] corner2_x;
	logic signed [31:0] corner2_y;
	logic signed [31:0] corner3_x;
	logic signed [31:0] corner3_y;
	logic signed [31:0] corner4_x;
	logic signed [31:0] corner4_y;

	// Percent chance per cycle that the sender idles / the receiver stalls
	int idle_pct;
	int stall_pct;
	int quiet_cycles = 0;

	corner_scoreboard sb = new();

	rotated_rectangle_corners uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.mid_x       (mid_x),
		.mid_y       (mid_y),
		.length_x    (length_x),
		.length_y    (length_y),
		.angle       (angle),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.corner1_x   (corner1_x),
		.corner1_y   (corner1_y),
		.corner2_x   (corner2_x),
		.corner2_y   (corner2_y),
		.corner3_x   (corner3_x),
		.corner3_y   (corner3_y),
		.corner4_x   (corner4_x),
		.corner4_y   (corner4_y)
	);

	always #10 clk = ~clk;

	// Receiver side: check each accepted output transaction, then pick a
	// fresh stall for the next edge. Stall is random every cycle whether or
	// not a result is waiting, so it lands on every phase of the pipeline.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_corners(corners_t'{corner1_x, corner1_y, corner2_x, corner2_y,
				corner3_x, corner3_y, corner4_x, corner4_y});
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a run of cycles with no transaction on either side is a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one rectangle: random idle cycles first, then hold valid and
	// payload steady until the edge where stall is low. Entered and left
	// right after a rising edge, so every drive here is a single NBA per step.
	task send_rect(input logic signed [31:0] mx, input logic signed [31:0] my,
		input logic [23:0] lx, input logic [23:0] ly, input logic signed [16:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mid_x      <= mx;
		mid_y      <= my;
		length_x   <= lx;
		length_y   <= ly;
		angle      <= ang;
		do begin
			@(posedge clk);
		end while (item_stall);
		sb.note_rect(geom_t'{mx, my, lx, ly}, ang);
	endtask

	// Midpoints: mostly anywhere, with a good share parked near the rails so
	// the corner saturation gets exercised in both directions.
	function logic signed [31:0] pick_mid();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'sh7FFF_0000 + 32'($urandom_range(16'hFFFF));
			2: return 32'sh8000_0000 + 32'($urandom_range(16'hFFFF));
			default: return 32'($signed($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function logic [23:0] pick_len();
		case ($urandom_range(4))
			0: return 24'd0;
			1: return LEN_MAX - 24'($urandom_range(255));
			2: return 24'($urandom_range(4095));
			default: return 24'($urandom);
		endcase
	endfunction

	task send_random_rect();
		logic signed [16:0] ang;
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic [23:0] lx;
		logic [23:0] ly;
		// Half the angles are drawn from a 45 degree grid that starts at -65536 (1/128
		// degree units), each moved by up to 3 units either way.
		if ($urandom_range(1) == 0) begin
			ang = 17'($urandom);
		end else begin
			ang = 17'($signed($urandom_range(22)) * DEG_45 - 65536 +
				17'($signed($urandom_range(6)) - 3));
		end
		mx = pick_mid();
		my = pick_mid();
		lx = pick_len();
		ly = pick_len();
		send_rect(mx, my, lx, ly, ang);
	endtask

	task drain_results();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		mid_x        = '0;
		mid_y        = '0;
		length_x     = '0;
		length_y     = '0;
		angle        = '0;
		idle_pct     = 0;
		stall_pct    = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate, axis-aligned and 45 degree rectangles
		send_rect(32'sd0, 32'sd0, 24'd0, 24'd0, 17'sd0);
		send_rect(32'sd1000, -32'sd1000, 24'd0, 24'd0, 17'sd1234);
		send_rect(32'sd0, 32'sd0, 24'd512, 24'd256, 17'sd0);
		send_rect(32'sd0, 32'sd0, 24'd512, 24'd256, DEG_90);
		send_rect(32'sd0, 32'sd0, 24'd512, 24'd256, DEG_180);
		send_rect(32'sd0, 32'sd0, 24'd512, 24'd256, DEG_270);
		send_rect(32'sd0, 32'sd0, 24'd512, 24'd256, DEG_45);
		// Wrap beyond one turn, negative angles and the field extremes
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, DEG_360);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, -DEG_360);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, 17'sh0FFFF);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, 17'sh10000);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, -17'sd1);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, DEG_360 - 17'sd1);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, DEG_90 + 17'sd1);
		send_rect(32'sd256, 32'sd256, 24'd1024, 24'd2048, DEG_270 - 17'sd1);
		// Largest lengths with midpoints at the rails or origin, then bit patterns: corners saturate both ways
		send_rect(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, LEN_MAX, LEN_MAX, 17'sd0);
		send_rect(32'sh8000_0000, 32'sh8000_0000, LEN_MAX, LEN_MAX, 17'sd0);
		send_rect(32'sh7FFF_FFFF, 32'sh8000_0000, LEN_MAX, LEN_MAX, DEG_45);
		send_rect(32'sh8000_0000, 32'sh7FFF_FFFF, LEN_MAX, 24'd0, DEG_180 + 17'sd77);
		send_rect(32'sd0, 32'sd0, LEN_MAX, LEN_MAX, -DEG_45);
		send_rect(32'sh5555_5555, 32'shAAAA_AAAA, 24'h555555, 24'hAAAAAA, 17'sh0AAAA);
		send_rect(32'shAAAA_AAAA, 32'sh5555_5555, 24'hAAAAAA, 24'h555555, 17'sh15555);
		item_valid <= 1'b0;
		drain_results();

		// Random phases: free running, sparse sender, heavy back-pressure,
		// then light noise on both sides.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			repeat (ITEMS_PER_PHASE) send_random_rect();
			item_valid <= 1'b0;
			drain_results();
		end

		// Let anything stray fall out of the pipeline before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
